// ===== rtl/wfrt_pkg.sv =====
// ----------------------------------------------------------------------------
// wfrt_pkg
// Shared types and codes for the ranked word frequency table.
// ----------------------------------------------------------------------------
package wfrt_pkg;

    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 24;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;  // 'Z'

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_RANK = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_RANK   = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJ  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LONG = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd3;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SLCMP = 13'b0000000000010,
        ST_CCMP  = 13'b0000000000100,
        ST_NEW   = 13'b0000000001000,
        ST_CPWR  = 13'b0000000010000,
        ST_FCNT  = 13'b0000000100000,
        ST_QCHK  = 13'b0000001000000,
        ST_QCNT  = 13'b0000010000000,
        ST_ROT   = 13'b0000100000000,
        ST_FIN   = 13'b0001000000000,
        ST_RSLOT = 13'b0010000000000,
        ST_RLEN  = 13'b0100000000000,
        ST_RCHR  = 13'b1000000000000
    } wfrt_state_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] ch);
        return ((ch >= CHAR_LO_A) && (ch <= CHAR_LO_Z)) ||
               ((ch >= CHAR_UP_A) && (ch <= CHAR_UP_Z));
    endfunction

endpackage

// ===== rtl/word_frequency_ranked_table.sv =====
// ----------------------------------------------------------------------------
// word_frequency_ranked_table
// Counts letter-only words and keeps them in descending count order.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (opcode, char_code, last_char, rank_index) is taken
//   at a rising edge with start high and busy low. Opcode 0 feeds one token
//   character; opcode 1 reads the entry at rank_index.
//   Result channel: result_valid marks each result for one cycle. The
//   receiver cannot stall, so results are never held.
// Sequence:
//   A non-final token character leaves the block idle. A final character gives
//   its status in the next cycle when rejected or too long. An accepted word
//   runs a slot-by-slot search when the table holds entries, comparing the
//   characters of each slot whose length matches, all through the one read
//   port of each memory. A new word then copies its letters unless the table
//   is full. A known word updates its count, scans the rank list for its new
//   place and, when it moves, shifts the entries between back and writes
//   itself there. A rank read looks up the slot, length and count, then gives
//   1 character per cycle; an out-of-range rank answers in the next cycle.
// Reset: clears the token state and the entry count; the memories need no
//   clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
module word_frequency_ranked_table #(
    parameter int MAX_WORDS    = 1024,
    parameter int MAX_WORD_LEN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           opcode,
    input  logic [wfrt_pkg::CHAR_W-1:0]    char_code,
    input  logic                           last_char,
    input  logic [wfrt_pkg::RANK_W-1:0]    rank_index,
    output logic                           result_valid,
    output logic                           kind,
    output logic [wfrt_pkg::STATUS_W-1:0]  status,
    output logic [wfrt_pkg::COUNT_W-1:0]   count,
    output logic [wfrt_pkg::CHAR_W-1:0]    out_char,
    output logic                           last_out,
    output logic                           entry_valid
);
    import wfrt_pkg::*;

    localparam int SW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int EW   = $clog2(MAX_WORDS + 1);
    localparam int IW   = $clog2(MAX_WORD_LEN);
    localparam int LENW = $clog2(MAX_WORD_LEN + 1);
    localparam int CW   = (EW > RANK_W) ? EW : RANK_W;
    localparam int WDEP = MAX_WORDS * (2 ** IW);

    // Memories
    logic [CHAR_W-1:0]  tok_mem [MAX_WORD_LEN];
    logic [CHAR_W-1:0]  wd_mem  [WDEP];
    logic [LENW-1:0]    len_mem [MAX_WORDS];
    logic [COUNT_W-1:0] cnt_mem [MAX_WORDS];
    logic [SW-1:0]      rk_mem  [MAX_WORDS];

    logic               tok_we;
    logic [IW-1:0]      tok_waddr, tok_raddr;
    logic [CHAR_W-1:0]  tok_wdata, tok_rd;
    logic               wd_we;
    logic [SW+IW-1:0]   wd_waddr, wd_raddr;
    logic [CHAR_W-1:0]  wd_wdata, wd_rd;
    logic               len_we;
    logic [SW-1:0]      len_waddr, len_raddr;
    logic [LENW-1:0]    len_wdata, len_rd;
    logic               cnt_we;
    logic [SW-1:0]      cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rd;
    logic               rk_we;
    logic [SW-1:0]      rk_waddr, rk_raddr;
    logic [SW-1:0]      rk_wdata, rk_rd;

    // Control and payload registers
    wfrt_state_t        state_reg, state_next;
    logic [LENW-1:0]    tlen_reg, tlen_next;
    logic               started_reg, started_next;
    logic               bad_reg, bad_next;
    logic               long_reg, long_next;
    logic [EW-1:0]      ec_reg, ec_next;
    logic [LENW-1:0]    wlen_reg, wlen_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [SW-1:0]      k_reg, k_next;
    logic [SW-1:0]      q_reg, q_next;
    logic [SW-1:0]      carry_reg, carry_next;
    logic [COUNT_W-1:0] c_reg, c_next;
    logic               rv_reg, rv_next;
    logic               kind_reg, kind_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [COUNT_W-1:0] cntout_reg, cntout_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic               lo_reg, lo_next;
    logic               ev_reg, ev_next;

    logic               accept;
    logic               letter, keep, first_chr;
    logic [LENW-1:0]    tlen_new;
    logic               bad_new, long_new;
    logic               last_slot, last_idx;
    logic [CW-1:0]      rank_ext;
    logic [SW-1:0]      ec_slot;

    assign accept    = start && (state_reg == ST_IDLE);
    assign letter    = is_letter(char_code);
    assign first_chr = !started_reg;
    assign keep      = letter && (tlen_reg < LENW'(MAX_WORD_LEN));
    assign tlen_new  = keep ? (tlen_reg + LENW'(1)) : tlen_reg;
    assign bad_new   = bad_reg || (!letter && !first_chr && !last_char);
    assign long_new  = long_reg || (letter && !keep);
    assign last_slot = ((EW'(s_reg) + EW'(1)) == ec_reg);
    assign last_idx  = ((LENW'(i_reg) + LENW'(1)) == wlen_reg);
    assign rank_ext  = CW'(rank_index);
    assign ec_slot   = ec_reg[SW-1:0];

    // Memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tok_we)
        begin
            tok_mem[tok_waddr] <= tok_wdata;
        end
        tok_rd <= tok_mem[tok_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wd_we)
        begin
            wd_mem[wd_waddr] <= wd_wdata;
        end
        wd_rd <= wd_mem[wd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rd <= len_mem[len_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_waddr] <= rk_wdata;
        end
        rk_rd <= rk_mem[rk_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        tlen_next    = tlen_reg;
        started_next = started_reg;
        bad_next     = bad_reg;
        long_next    = long_reg;
        ec_next      = ec_reg;
        wlen_next    = wlen_reg;
        s_next       = s_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        q_next       = q_reg;
        carry_next   = carry_reg;
        c_next       = c_reg;
        rv_next      = 1'b0;
        kind_next    = kind_reg;
        stat_next    = stat_reg;
        cntout_next  = cntout_reg;
        ch_next      = ch_reg;
        lo_next      = lo_reg;
        ev_next      = ev_reg;

        tok_we    = 1'b0;
        tok_waddr = tlen_reg[IW-1:0];
        tok_wdata = char_code;
        tok_raddr = i_reg;
        wd_we     = 1'b0;
        wd_waddr  = {ec_slot, i_reg};
        wd_wdata  = tok_rd;
        wd_raddr  = {s_reg, i_reg};
        len_we    = 1'b0;
        len_waddr = ec_slot;
        len_wdata = wlen_reg;
        len_raddr = s_reg;
        cnt_we    = 1'b0;
        cnt_waddr = ec_slot;
        cnt_wdata = COUNT_W'(1);
        cnt_raddr = s_reg;
        rk_we     = 1'b0;
        rk_waddr  = ec_slot;
        rk_wdata  = ec_slot;
        rk_raddr  = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_RANK))
                begin
                    if (rank_ext >= CW'(ec_reg))
                    begin
                        rv_next     = 1'b1;
                        kind_next   = KIND_RANK;
                        stat_next   = STAT_OK;
                        cntout_next = '0;
                        ch_next     = '0;
                        lo_next     = 1'b1;
                        ev_next     = 1'b0;
                    end
                    else
                    begin
                        rk_raddr   = rank_ext[SW-1:0];
                        state_next = ST_RSLOT;
                    end
                end
                else if (accept)
                begin
                    // collect the character, then judge the token at its end
                    tok_we = keep;
                    if (!last_char)
                    begin
                        tlen_next    = tlen_new;
                        started_next = 1'b1;
                        bad_next     = bad_new;
                        long_next    = long_new;
                    end
                    else
                    begin
                        tlen_next    = '0;
                        started_next = 1'b0;
                        bad_next     = 1'b0;
                        long_next    = 1'b0;
                        wlen_next    = tlen_new;
                        if (bad_new || (tlen_new == '0) || long_new)
                        begin
                            rv_next     = 1'b1;
                            kind_next   = KIND_STATUS;
                            stat_next   = (bad_new || (tlen_new == '0)) ? STAT_REJ
                                                                          : STAT_LONG;
                            cntout_next = '0;
                            ch_next     = '0;
                            lo_next     = 1'b1;
                            ev_next     = 1'b0;
                        end
                        else if (ec_reg == '0)
                        begin
                            state_next = ST_NEW;
                        end
                        else
                        begin
                            s_next     = '0;
                            len_raddr  = '0;
                            state_next = ST_SLCMP;
                        end
                    end
                end
            end

            ST_SLCMP:
            begin
                if (len_rd == wlen_reg)
                begin
                    i_next     = '0;
                    wd_raddr   = {s_reg, {IW{1'b0}}};
                    tok_raddr  = '0;
                    state_next = ST_CCMP;
                end
                else if (last_slot)
                begin
                    state_next = ST_NEW;
                end
                else
                begin
                    s_next    = s_reg + SW'(1);
                    len_raddr = s_reg + SW'(1);
                end
            end

            ST_CCMP:
            begin
                if (wd_rd == tok_rd)
                begin
                    if (last_idx)
                    begin
                        cnt_raddr  = s_reg;
                        state_next = ST_FCNT;
                    end
                    else
                    begin
                        i_next    = i_reg + IW'(1);
                        wd_raddr  = {s_reg, i_reg + IW'(1)};
                        tok_raddr = i_reg + IW'(1);
                    end
                end
                else if (last_slot)
                begin
                    state_next = ST_NEW;
                end
                else
                begin
                    s_next     = s_reg + SW'(1);
                    len_raddr  = s_reg + SW'(1);
                    state_next = ST_SLCMP;
                end
            end

            ST_NEW:
            begin
                if (ec_reg == EW'(MAX_WORDS))
                begin
                    rv_next     = 1'b1;
                    kind_next   = KIND_STATUS;
                    stat_next   = STAT_FULL;
                    cntout_next = '0;
                    ch_next     = '0;
                    lo_next     = 1'b1;
                    ev_next     = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    i_next     = '0;
                    tok_raddr  = '0;
                    state_next = ST_CPWR;
                end
            end

            ST_CPWR:
            begin
                // copy one letter into the new slot
                wd_we = 1'b1;
                if (last_idx)
                begin
                    len_we      = 1'b1;
                    cnt_we      = 1'b1;
                    rk_we       = 1'b1;
                    ec_next     = ec_reg + EW'(1);
                    rv_next     = 1'b1;
                    kind_next   = KIND_STATUS;
                    stat_next   = STAT_OK;
                    cntout_next = COUNT_W'(1);
                    ch_next     = '0;
                    lo_next     = 1'b1;
                    ev_next     = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    i_next    = i_reg + IW'(1);
                    tok_raddr = i_reg + IW'(1);
                end
            end

            ST_FCNT:
            begin
                c_next     = (cnt_rd == COUNT_MAX) ? cnt_rd : (cnt_rd + COUNT_W'(1));
                cnt_we     = 1'b1;
                cnt_waddr  = s_reg;
                cnt_wdata  = (cnt_rd == COUNT_MAX) ? cnt_rd : (cnt_rd + COUNT_W'(1));
                k_next     = '0;
                rk_raddr   = '0;
                state_next = ST_QCHK;
            end

            ST_QCHK:
            begin
                if (rk_rd == s_reg)
                begin
                    // already in place
                    rv_next     = 1'b1;
                    kind_next   = KIND_STATUS;
                    stat_next   = STAT_OK;
                    cntout_next = c_reg;
                    ch_next     = '0;
                    lo_next     = 1'b1;
                    ev_next     = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    carry_next = rk_rd;
                    cnt_raddr  = rk_rd;
                    state_next = ST_QCNT;
                end
            end

            ST_QCNT:
            begin
                k_next   = k_reg + SW'(1);
                rk_raddr = k_reg + SW'(1);
                if (cnt_rd < c_reg)
                begin
                    q_next     = k_reg;
                    state_next = ST_ROT;
                end
                else
                begin
                    state_next = ST_QCHK;
                end
            end

            ST_ROT:
            begin
                // shift one entry back until the moved slot is reached
                rk_we      = 1'b1;
                rk_waddr   = k_reg;
                rk_wdata   = carry_reg;
                carry_next = rk_rd;
                if (rk_rd == s_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    k_next   = k_reg + SW'(1);
                    rk_raddr = k_reg + SW'(1);
                end
            end

            ST_FIN:
            begin
                rk_we       = 1'b1;
                rk_waddr    = q_reg;
                rk_wdata    = s_reg;
                rv_next     = 1'b1;
                kind_next   = KIND_STATUS;
                stat_next   = STAT_OK;
                cntout_next = c_reg;
                ch_next     = '0;
                lo_next     = 1'b1;
                ev_next     = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_RSLOT:
            begin
                s_next     = rk_rd;
                len_raddr  = rk_rd;
                cnt_raddr  = rk_rd;
                state_next = ST_RLEN;
            end

            ST_RLEN:
            begin
                wlen_next  = ((len_rd == '0) || (len_rd > LENW'(MAX_WORD_LEN))) ?
                             LENW'(1) : len_rd;
                c_next     = cnt_rd;
                i_next     = '0;
                wd_raddr   = {s_reg, {IW{1'b0}}};
                state_next = ST_RCHR;
            end

            ST_RCHR:
            begin
                rv_next     = 1'b1;
                kind_next   = KIND_RANK;
                stat_next   = STAT_OK;
                cntout_next = c_reg;
                ch_next     = wd_rd;
                lo_next     = last_idx;
                ev_next     = 1'b1;
                if (last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next   = i_reg + IW'(1);
                    wd_raddr = {s_reg, i_reg + IW'(1)};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tlen_reg    <= '0;
            started_reg <= 1'b0;
            bad_reg     <= 1'b0;
            long_reg    <= 1'b0;
            ec_reg      <= '0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tlen_reg    <= tlen_next;
            started_reg <= started_next;
            bad_reg     <= bad_next;
            long_reg    <= long_next;
            ec_reg      <= ec_next;
            rv_reg      <= rv_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        wlen_reg   <= wlen_next;
        s_reg      <= s_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        q_reg      <= q_next;
        carry_reg  <= carry_next;
        c_reg      <= c_next;
        kind_reg   <= kind_next;
        stat_reg   <= stat_next;
        cntout_reg <= cntout_next;
        ch_reg     <= ch_next;
        lo_reg     <= lo_next;
        ev_reg     <= ev_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign status       = stat_reg;
    assign count        = cntout_reg;
    assign out_char     = ch_reg;
    assign last_out     = lo_reg;
    assign entry_valid  = ev_reg;

endmodule

// ===== rtl/wfrt_checker.sv =====
// ----------------------------------------------------------------------------
// wfrt_checker
// Port-level checks on the ranked word frequency table.
// ----------------------------------------------------------------------------
module wfrt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          opcode,
    input logic                          last_char,
    input logic                          result_valid,
    input logic                          kind,
    input logic [wfrt_pkg::STATUS_W-1:0] status,
    input logic [wfrt_pkg::COUNT_W-1:0]  count,
    input logic [wfrt_pkg::CHAR_W-1:0]   out_char,
    input logic                          last_out,
    input logic                          entry_valid
);
    import wfrt_pkg::*;

    // a status result closes its run and carries no character
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_STATUS)) |-> (last_out && (out_char == '0)))
        else $error("status result malformed");

    // a failed token refers to no entry
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_STATUS) && (status != STAT_OK))
        |-> ((count == '0) && !entry_valid))
        else $error("failed token shows an entry");

    // an accepted word has a live entry with a nonzero count
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_STATUS) && (status == STAT_OK))
        |-> (entry_valid && (count != '0)))
        else $error("accepted word without count");

    // a middle character gives no result and keeps the block free
    a_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_CHAR) && !last_char)
        |=> (!result_valid && !busy))
        else $error("middle character produced activity");

endmodule

bind word_frequency_ranked_table wfrt_checker u_wfrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .last_char    (last_char),
    .result_valid (result_valid),
    .kind         (kind),
    .status       (status),
    .count        (count),
    .out_char     (out_char),
    .last_out     (last_out),
    .entry_valid  (entry_valid)
);
